@@ design/smf_pkg.sv @@
// ----------------------------------------------------------------------------
// smf_pkg
// shared constants and types of the clamped 3x3 smoothing filter
// ----------------------------------------------------------------------------
package smf_pkg;

    // default geometry limits and sample format
    localparam int DEF_MAX_WIDTH   = 4096;
    localparam int DEF_SAMPLE_BITS = 16;

    // configuration port
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = CFG_W'(1920);
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = CFG_W'(1080);

    // row counter and height clamp
    localparam int                ROW_W        = 12;
    localparam logic [CFG_W-1:0]  HEIGHT_LIMIT = CFG_W'(4096);

    // pending result slots of one item, emitted lowest first
    localparam int EMIT_SLOTS = 4;

    // which taps a result uses
    typedef struct packed {
        logic row_end;   // columns (1,2,2) instead of (0,1,2)
        logic last_row;  // rows (mid,bottom,bottom) instead of (top,mid,bottom)
    } t_tap_sel;

endpackage

@@ design/smf_if.sv @@
// ----------------------------------------------------------------------------
// smf stream interfaces
// sample, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface smf_sample_if #(
    parameter int SAMPLE_BITS = smf_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

interface smf_result_if #(
    parameter int SAMPLE_BITS = smf_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] filtered_value;
    logic                          last_of_run;
    logic                          last_of_frame;

    modport source (output valid, output filtered_value, output last_of_run,
                    output last_of_frame, input ready);
    modport sink   (input valid, input filtered_value, input last_of_run,
                    input last_of_frame, output ready);
endinterface

interface smf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [smf_pkg::CFG_IDX_W-1:0]  index;
    logic [smf_pkg::CFG_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/smf_tap_sum.sv @@
// ----------------------------------------------------------------------------
// smf_tap_sum
// weighted (1,6,1)x(1,6,1) sum of the window, rounded and shifted by six
// ----------------------------------------------------------------------------
module smf_tap_sum #(
    parameter int SAMPLE_BITS = smf_pkg::DEF_SAMPLE_BITS
) (
    input  logic signed [SAMPLE_BITS-1:0] i_win [3][3],
    input  smf_pkg::t_tap_sel             i_sel,
    output logic signed [SAMPLE_BITS-1:0] o_value
);
    import smf_pkg::*;

    localparam int SW = SAMPLE_BITS + 7;

    logic signed [SW-1:0] col_sum [3];
    logic signed [SW-1:0] left_sum;
    logic signed [SW-1:0] centre_sum;
    logic signed [SW-1:0] right_sum;
    logic signed [SW-1:0] total;

    // vertical sums, one per window column
    always_comb begin
        logic signed [SW-1:0] t;
        logic signed [SW-1:0] m;
        logic signed [SW-1:0] b;
        for (int k = 0; k < 3; k++) begin
            t = SW'(i_win[k][0]);
            m = SW'(i_win[k][1]);
            b = SW'(i_win[k][2]);
            if (i_sel.last_row) begin
                col_sum[k] = m + (b <<< 2) + (b <<< 1) + b;
            end else begin
                col_sum[k] = t + (m <<< 2) + (m <<< 1) + b;
            end
        end
    end

    assign left_sum   = i_sel.row_end ? col_sum[1] : col_sum[0];
    assign centre_sum = i_sel.row_end ? col_sum[2] : col_sum[1];
    assign right_sum  = col_sum[2];

    assign total   = left_sum + (centre_sum <<< 2) + (centre_sum <<< 1) + right_sum
                   + SW'(32);
    assign o_value = total[SAMPLE_BITS+5:6];

endmodule

@@ design/smoothing_filter_3x3_clamped.sv @@
// ----------------------------------------------------------------------------
// smoothing_filter_3x3_clamped
// streaming 3x3 (1,6,1) smoothing filter with clamped frame edges
// ----------------------------------------------------------------------------
// Takes one sample plane in raster order, one sample per item, and gives each
// pixel as (sum of 36*centre + 6*edge + 1*corner neighbours + 32) >> 6, with
// neighbours outside the frame replaced by the nearest edge sample. Results
// trail the input by one row and one column: row 0 gives none unless it is
// also the last row, an ordinary item gives one, a row end gives two and the
// last row doubles that, up to four for the final pixel. The block takes one
// item per cycle as long as each item gives at most one result and the output
// is not stalled; an item with several results holds the input side until its
// last result has gone into the single output register, which drains one
// result per cycle while the result side is ready. An item passes stage 1,
// the window registers and the output register. The two rows above are kept
// in two row memories (one read and one write per cycle, registered read)
// that need no clearing pass: their content after reset is never used.
// Geometry is written through the config channel (index 0 frame_width, index
// 1 frame_height); the user must do so between items, which the block does
// not enforce. A width or height of 0 counts as 1, too large ones are clamped.
// ----------------------------------------------------------------------------
module smoothing_filter_3x3_clamped #(
    parameter int MAX_WIDTH   = smf_pkg::DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = smf_pkg::DEF_SAMPLE_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    smf_sample_if.sink   i_sample,
    smf_result_if.source o_result,
    smf_cfg_if.sink      i_cfg
);
    import smf_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CMP_W = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg.data;
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // clamped geometry
    logic [CMP_W-1:0] width_eff;
    logic [CFG_W-1:0] height_eff;

    always_comb begin
        if (r_frame_width == '0) begin
            width_eff = CMP_W'(1);
        end else if (CMP_W'(r_frame_width) > CMP_W'(MAX_WIDTH)) begin
            width_eff = CMP_W'(MAX_WIDTH);
        end else begin
            width_eff = CMP_W'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            height_eff = CFG_W'(1);
        end else if (r_frame_height > HEIGHT_LIMIT) begin
            height_eff = HEIGHT_LIMIT;
        end else begin
            height_eff = r_frame_height;
        end
    end

    // ------------------------------------------------------------------
    // handshake control
    // ------------------------------------------------------------------
    logic                    r_s1_valid;
    logic [EMIT_SLOTS-1:0]   r_e_mask;     // pending results of the item in emit
    logic                    r_out_valid;
    logic                    in_fire;
    logic                    s1_adv;
    logic                    e_fire;
    logic [EMIT_SLOTS-1:0]   e_lowest;
    logic [EMIT_SLOTS-1:0]   e_rest;
    logic                    e_empty_next;

    assign e_lowest     = r_e_mask & (~r_e_mask + EMIT_SLOTS'(1));
    assign e_rest       = r_e_mask & ~e_lowest;
    assign e_fire       = (r_e_mask != '0) && (!r_out_valid || o_result.ready);
    assign e_empty_next = (r_e_mask == '0) || (e_fire && (e_rest == '0));
    // the window may move on only once the emit stage is done with it
    assign s1_adv       = r_s1_valid && e_empty_next;
    assign i_sample.ready = !r_s1_valid || s1_adv;
    assign in_fire      = i_sample.valid && i_sample.ready;

    // ------------------------------------------------------------------
    // position counters, advanced per accepted item
    // ------------------------------------------------------------------
    logic [AW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [AW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;
    logic             row_end;
    logic             last_row;

    assign row_end  = (CMP_W'(r_col) + CMP_W'(1)) >= width_eff;
    assign last_row = (CFG_W'(r_row) + CFG_W'(1)) >= height_eff;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_fire) begin
            if (row_end) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: item waiting on its row memory read
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] r_s1_x;
    logic [AW-1:0]                 r_s1_c;
    logic                          r_s1_row0;
    logic                          r_s1_row1;
    logic                          r_s1_col0;
    logic                          r_s1_row_end;
    logic                          r_s1_last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_x        <= i_sample.sample_value;
            r_s1_c        <= r_col;
            r_s1_row0     <= (r_row == '0);
            r_s1_row1     <= (r_row == ROW_W'(1));
            r_s1_col0     <= (r_col == '0);
            r_s1_row_end  <= row_end;
            r_s1_last_row <= last_row;
        end
    end

    // ------------------------------------------------------------------
    // row memories: read at accept, written back when stage 1 moves on
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] mem_prev [MAX_WIDTH];
    logic signed [SAMPLE_BITS-1:0] mem_old  [MAX_WIDTH];
    logic signed [SAMPLE_BITS-1:0] r_rd_prev;
    logic signed [SAMPLE_BITS-1:0] r_rd_old;
    logic signed [SAMPLE_BITS-1:0] prev_eff;
    logic signed [SAMPLE_BITS-1:0] old_eff;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            mem_prev[r_s1_c] <= r_s1_x;
            mem_old[r_s1_c]  <= prev_eff;
        end
        if (in_fire) begin
            r_rd_prev <= mem_prev[r_col];
            r_rd_old  <= mem_old[r_col];
        end
    end

    // a write and a read of the same entry in one cycle (one-pixel rows)
    // returns stale data, so the written values are forwarded
    logic                          r_fwd;
    logic signed [SAMPLE_BITS-1:0] r_fwd_prev;
    logic signed [SAMPLE_BITS-1:0] r_fwd_old;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (in_fire) begin
            r_fwd <= s1_adv && (r_s1_c == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_fwd_prev <= r_s1_x;
            r_fwd_old  <= prev_eff;
        end
    end

    assign prev_eff = r_fwd ? r_fwd_prev : r_rd_prev;
    assign old_eff  = r_fwd ? r_fwd_old  : r_rd_old;

    // new window column with top-edge clamping
    logic signed [SAMPLE_BITS-1:0] top_tap;
    logic signed [SAMPLE_BITS-1:0] mid_tap;

    always_comb begin
        if (r_s1_row0) begin
            mid_tap = r_s1_x;
            top_tap = r_s1_x;
        end else if (r_s1_row1) begin
            mid_tap = prev_eff;
            top_tap = prev_eff;
        end else begin
            mid_tap = prev_eff;
            top_tap = old_eff;
        end
    end

    // ------------------------------------------------------------------
    // window registers [column oldest..newest][row top,mid,bottom]
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] r_win [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[k][j] <= '0;
                end
            end
        end else if (s1_adv) begin
            if (r_s1_col0) begin
                // left-edge clamp: fill all columns with the first one
                for (int k = 0; k < 3; k++) begin
                    r_win[k][0] <= top_tap;
                    r_win[k][1] <= mid_tap;
                    r_win[k][2] <= r_s1_x;
                end
            end else begin
                for (int k = 0; k < 2; k++) begin
                    for (int j = 0; j < 3; j++) begin
                        r_win[k][j] <= r_win[k+1][j];
                    end
                end
                r_win[2][0] <= top_tap;
                r_win[2][1] <= mid_tap;
                r_win[2][2] <= r_s1_x;
            end
        end
    end

    // ------------------------------------------------------------------
    // emit stage: slot 0 normal, 1 row end, 2 last row, 3 last row end
    // ------------------------------------------------------------------
    logic [EMIT_SLOTS-1:0] n_e_mask;

    always_comb begin
        n_e_mask = r_e_mask;
        if (e_fire) begin
            n_e_mask = e_rest;
        end
        if (s1_adv) begin
            n_e_mask[0] = !r_s1_row0 && !r_s1_col0;
            n_e_mask[1] = !r_s1_row0 && r_s1_row_end;
            n_e_mask[2] = r_s1_last_row && !r_s1_col0;
            n_e_mask[3] = r_s1_last_row && r_s1_row_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_mask <= '0;
        end else begin
            r_e_mask <= n_e_mask;
        end
    end

    t_tap_sel                      tap_sel;
    logic signed [SAMPLE_BITS-1:0] tap_value;

    assign tap_sel.row_end  = e_lowest[1] | e_lowest[3];
    assign tap_sel.last_row = e_lowest[2] | e_lowest[3];

    smf_tap_sum #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_tap_sum (
        .i_win   (r_win),
        .i_sel   (tap_sel),
        .o_value (tap_value)
    );

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] r_out_value;
    logic                          r_out_last_run;
    logic                          r_out_last_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (e_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_fire) begin
            r_out_value      <= tap_value;
            r_out_last_run   <= (e_rest == '0);
            r_out_last_frame <= e_lowest[3];
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.filtered_value = r_out_value;
    assign o_result.last_of_run    = r_out_last_run;
    assign o_result.last_of_frame  = r_out_last_frame;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    // forwarding is only needed for one-pixel rows
    a_fwd_col0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_fwd) |-> (r_s1_c == '0))
        else $error("forwarding hit outside column zero");

    // the frame-end result always closes its item's run
    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.last_of_frame) |-> o_result.last_of_run)
        else $error("frame end without end of run");

    // stage 1 never moves on while the emit stage still holds results
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |-> ($countones(r_e_mask) <= 1) && (r_e_mask == '0 || e_fire))
        else $error("window updated under pending results");

    // nothing is shown right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid after reset");
`endif

endmodule
